@@ hw/rtl/tpc_pkg.sv @@
// Shared constants, codes and types of the three-phase PWM compare calculator.
package tpc_pkg;

  // Fixed field widths
  localparam int FREQ_W     = 16;
  localparam int DUTY_W     = 13;
  localparam int CMP_W      = 16;
  localparam int PRE_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Saturation limits and the prescale threshold shift
  localparam logic [CMP_W-1:0] CMP_MAX   = 16'd65535;
  localparam logic [PRE_W-1:0] PRE_MAX   = 3'd7;
  localparam int               PRE_SHIFT = 16;

  // Configuration register reset values
  localparam logic [FREQ_W-1:0] PWM_FREQ_RST = 16'd8000;
  localparam logic [FREQ_W-1:0] FREQ_MIN_RST = 16'd1;
  localparam logic [FREQ_W-1:0] FREQ_MAX_RST = 16'd65535;

  // Parameter defaults
  localparam int BUS_CLOCK_HZ_DEF = 48000000;
  localparam int DUTY_BITS_DEF    = 12;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PWM_FREQ = 2'd0,
    CFG_FREQ_MIN = 2'd1,
    CFG_FREQ_MAX = 2'd2,
    CFG_CENTER   = 2'd3
  } cfg_reg_t;

  // Timing settings handed from the period unit to the datapath
  typedef struct packed {
    logic             run;
    logic             center;
    logic [PRE_W-1:0] prescale;
    logic [CMP_W-1:0] period;
  } tpc_timing_t;

endpackage

@@ hw/rtl/tpc_if.sv @@
// Valid/ready channel interfaces for the duty input and the compare result.

interface tpc_in_if;
  logic                      valid;
  logic                      ready;
  logic [tpc_pkg::DUTY_W-1:0] duty_a;
  logic [tpc_pkg::DUTY_W-1:0] duty_b;
  logic [tpc_pkg::DUTY_W-1:0] duty_c;

  modport source (output valid, output duty_a, output duty_b, output duty_c, input ready);
  modport sink   (input valid, input duty_a, input duty_b, input duty_c, output ready);
endinterface

interface tpc_out_if;
  logic                      valid;
  logic                      ready;
  logic [tpc_pkg::PRE_W-1:0] prescale_code;
  logic [tpc_pkg::CMP_W-1:0] period_count;
  logic [tpc_pkg::CMP_W-1:0] a_low_compare;
  logic [tpc_pkg::CMP_W-1:0] a_high_compare;
  logic [tpc_pkg::CMP_W-1:0] b_low_compare;
  logic [tpc_pkg::CMP_W-1:0] b_high_compare;
  logic [tpc_pkg::CMP_W-1:0] c_low_compare;
  logic [tpc_pkg::CMP_W-1:0] c_high_compare;

  modport source (
    output valid, output prescale_code, output period_count,
    output a_low_compare, output a_high_compare,
    output b_low_compare, output b_high_compare,
    output c_low_compare, output c_high_compare,
    input  ready
  );
  modport sink (
    input  valid, input prescale_code, input period_count,
    input  a_low_compare, input a_high_compare,
    input  b_low_compare, input b_high_compare,
    input  c_low_compare, input c_high_compare,
    output ready
  );
endinterface

@@ hw/rtl/tpc_period.sv @@
// Config registers, frequency clamp, prescale select and serial period divider.
module tpc_period #(
  parameter int BUS_CLOCK_HZ = tpc_pkg::BUS_CLOCK_HZ_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tpc_pkg::tpc_timing_t            timing
);

  // Numerator is (bus >> pre) + freq/2
  localparam int NUM_W = $clog2(BUS_CLOCK_HZ + (1 << (tpc_pkg::FREQ_W - 1)) + 1);
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [tpc_pkg::FREQ_W:0] THR   = (tpc_pkg::FREQ_W + 1)'(BUS_CLOCK_HZ >> tpc_pkg::PRE_SHIFT);
  localparam logic [NUM_W-1:0]         BUS_N = NUM_W'(BUS_CLOCK_HZ);

  typedef enum logic [3:0] {
    ST_PREP = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_RUN  = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [tpc_pkg::FREQ_W-1:0]    pwm_freq_r, freq_min_r, freq_max_r;
  logic                          center_r;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [NUM_W-1:0]              quo_r, quo_nxt;
  logic [tpc_pkg::FREQ_W-1:0]    rem_r, rem_nxt;
  logic [tpc_pkg::FREQ_W-1:0]    div_r, div_nxt;
  logic                          fzero_r, fzero_nxt;
  logic [tpc_pkg::PRE_W-1:0]     pre_r, pre_nxt;
  logic [tpc_pkg::CMP_W-1:0]     period_r, period_nxt;

  logic [tpc_pkg::FREQ_W-1:0]    freq_clamp;
  logic [tpc_pkg::PRE_W-1:0]     pre_calc;
  logic [tpc_pkg::FREQ_W:0]      rem_sh, rem_dif;
  logic                          rem_ge;
  logic [NUM_W-1:0]              quo_m1;

  // Clamp: max test wins when bounds cross
  always_comb begin
    if (pwm_freq_r > freq_max_r) begin
      freq_clamp = freq_max_r;
    end else if (pwm_freq_r < freq_min_r) begin
      freq_clamp = freq_min_r;
    end else begin
      freq_clamp = pwm_freq_r;
    end
  end

  // First prescale whose threshold the frequency exceeds, else the top code
  always_comb begin
    pre_calc = tpc_pkg::PRE_MAX;
    for (int p = 6; p >= 0; p--) begin
      if ({1'b0, freq_clamp} > (THR >> p)) begin
        pre_calc = tpc_pkg::PRE_W'(p);
      end
    end
  end

  // Restoring divide step, one quotient bit per cycle
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_r};
  assign rem_dif = rem_sh - {1'b0, div_r};
  assign quo_m1  = quo_r - NUM_W'(1);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    fzero_nxt  = fzero_r;
    pre_nxt    = pre_r;
    period_nxt = period_r;
    case (state_r)
      ST_PREP: begin
        quo_nxt   = (BUS_N >> pre_calc) + NUM_W'(freq_clamp >> 1);
        rem_nxt   = '0;
        div_nxt   = freq_clamp;
        fzero_nxt = (freq_clamp == '0);
        pre_nxt   = pre_calc;
        cnt_nxt   = CNT_W'(NUM_W);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? rem_dif[tpc_pkg::FREQ_W-1:0] : rem_sh[tpc_pkg::FREQ_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], rem_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Quotient minus one, saturated at both ends
        if (fzero_r) begin
          period_nxt = tpc_pkg::CMP_MAX;
        end else if (quo_r == '0) begin
          period_nxt = '0;
        end else if ((quo_m1 >> tpc_pkg::CMP_W) != '0) begin
          period_nxt = tpc_pkg::CMP_MAX;
        end else begin
          period_nxt = quo_m1[tpc_pkg::CMP_W-1:0];
        end
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_PREP;
      end
    endcase
    // Any config write restarts the timing calculation
    if (cfg_wr_en) begin
      state_nxt = ST_PREP;
    end
  end

  // Control state and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_PREP;
      pwm_freq_r <= tpc_pkg::PWM_FREQ_RST;
      freq_min_r <= tpc_pkg::FREQ_MIN_RST;
      freq_max_r <= tpc_pkg::FREQ_MAX_RST;
      center_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          tpc_pkg::CFG_PWM_FREQ: pwm_freq_r <= cfg_data;
          tpc_pkg::CFG_FREQ_MIN: freq_min_r <= cfg_data;
          tpc_pkg::CFG_FREQ_MAX: freq_max_r <= cfg_data;
          tpc_pkg::CFG_CENTER:   center_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    fzero_r  <= fzero_nxt;
    pre_r    <= pre_nxt;
    period_r <= period_nxt;
  end

  assign timing.run      = (state_r == ST_RUN);
  assign timing.center   = center_r;
  assign timing.prescale = pre_r;
  assign timing.period   = period_r;

endmodule

@@ hw/rtl/tpc_lane.sv @@
// One phase lane: duty scaling multiply, then edge or center compare pair.
module tpc_lane #(
  parameter int DUTY_BITS = tpc_pkg::DUTY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic [tpc_pkg::DUTY_W-1:0]   duty,
  input  logic [tpc_pkg::CMP_W-1:0]    period,
  input  logic                         center,
  output logic [tpc_pkg::CMP_W-1:0]    low_cmp,
  output logic [tpc_pkg::CMP_W-1:0]    high_cmp
);

  localparam int PROD_W = tpc_pkg::DUTY_W + tpc_pkg::CMP_W + 1;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] scaled, half, mid, sum;

  // Stage 1: duty times (period + 1)
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(duty) * PROD_W'({1'b0, period} + 17'd1);
    end
  end

  assign scaled = prod_r >> DUTY_BITS;
  assign half   = scaled >> 1;
  assign mid    = PROD_W'(period >> 1);
  assign sum    = mid + half;

  // Stage 2: compare pair with saturation
  always_comb begin
    if (center) begin
      low_cmp  = (half > mid) ? '0 : tpc_pkg::CMP_W'(mid - half);
      high_cmp = ((sum >> tpc_pkg::CMP_W) != '0) ? tpc_pkg::CMP_MAX
                                                 : sum[tpc_pkg::CMP_W-1:0];
    end else begin
      low_cmp  = '0;
      high_cmp = ((scaled >> tpc_pkg::CMP_W) != '0) ? tpc_pkg::CMP_MAX
                                                    : scaled[tpc_pkg::CMP_W-1:0];
    end
  end

endmodule

@@ hw/rtl/three_phase_pwm_compare_calc.sv @@
// Top level: three phase lanes, period unit and the merging output register.
//
// Usage:
//   in_chan carries three duty values (full scale 2**DUTY_BITS); out_chan
//   returns the prescale code, the period count and three compare pairs.
//   The cfg_ port writes pwm_frequency, frequency_min, frequency_max and
//   center_aligned by index; write it only while no transfer is in flight.
// Timing:
//   Prescale and period depend on configuration only. After reset and after
//   every config write the serial divider recomputes them, one quotient bit
//   per cycle, and in_chan.ready stays low until it is done. Config writes
//   are taken at any time. Afterwards one item is taken every cycle while
//   out_chan.ready stays high; a result passes through the multiply stage,
//   then the output register.
// Stall:
//   While out_chan.ready is low the result holds; one more item can enter
//   the multiply stage before in_chan.ready drops.
// Reset: synchronous active-low rst_n clears the pipeline and restores the
//   register defaults.
module three_phase_pwm_compare_calc #(
  parameter int BUS_CLOCK_HZ = tpc_pkg::BUS_CLOCK_HZ_DEF,
  parameter int DUTY_BITS    = tpc_pkg::DUTY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tpc_in_if.sink                         in_chan,
  tpc_out_if.source                      out_chan,
  input  logic                           cfg_wr_en,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LANES = 3;

  tpc_pkg::tpc_timing_t       timing;
  logic                       v1_r, v1_nxt;
  logic                       v2_r, v2_nxt;
  logic                       adv1, adv2, in_xfer;
  logic [tpc_pkg::DUTY_W-1:0] duty   [LANES];
  logic [tpc_pkg::CMP_W-1:0]  lo     [LANES];
  logic [tpc_pkg::CMP_W-1:0]  hi     [LANES];
  logic [tpc_pkg::CMP_W-1:0]  lo_r   [LANES];
  logic [tpc_pkg::CMP_W-1:0]  hi_r   [LANES];
  logic [tpc_pkg::PRE_W-1:0]  pre_r;
  logic [tpc_pkg::CMP_W-1:0]  period_r;

  tpc_period #(
    .BUS_CLOCK_HZ (BUS_CLOCK_HZ)
  ) u_period (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  // Pipeline flow control
  assign adv2          = !v2_r || out_chan.ready;
  assign adv1          = !v1_r || adv2;
  assign in_chan.ready = adv1 && timing.run;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign v1_nxt        = adv1 ? in_xfer : v1_r;
  assign v2_nxt        = adv2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  assign duty[0] = in_chan.duty_a;
  assign duty[1] = in_chan.duty_b;
  assign duty[2] = in_chan.duty_c;

  // Phase lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tpc_lane #(
      .DUTY_BITS (DUTY_BITS)
    ) u_lane (
      .clk      (clk),
      .load     (in_xfer),
      .duty     (duty[g]),
      .period   (timing.period),
      .center   (timing.center),
      .low_cmp  (lo[g]),
      .high_cmp (hi[g])
    );
  end

  // Merge lanes and timing into the output register
  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      pre_r    <= timing.prescale;
      period_r <= timing.period;
      for (int i = 0; i < LANES; i++) begin
        lo_r[i] <= lo[i];
        hi_r[i] <= hi[i];
      end
    end
  end

  assign out_chan.valid          = v2_r;
  assign out_chan.prescale_code  = pre_r;
  assign out_chan.period_count   = period_r;
  assign out_chan.a_low_compare  = lo_r[0];
  assign out_chan.a_high_compare = hi_r[0];
  assign out_chan.b_low_compare  = lo_r[1];
  assign out_chan.b_high_compare = hi_r[1];
  assign out_chan.c_low_compare  = lo_r[2];
  assign out_chan.c_high_compare = hi_r[2];

endmodule

@@ hw/rtl/tpc_checker.sv @@
// Port-level assertions for the compare calculator, bound to the top level.
module tpc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          cfg_wr_en,
  input logic [tpc_pkg::CMP_W-1:0]     period_count,
  input logic [tpc_pkg::CMP_W-1:0]     a_low,
  input logic [tpc_pkg::CMP_W-1:0]     a_high,
  input logic [tpc_pkg::CMP_W-1:0]     b_low,
  input logic [tpc_pkg::CMP_W-1:0]     b_high,
  input logic [tpc_pkg::CMP_W-1:0]     c_low,
  input logic [tpc_pkg::CMP_W-1:0]     c_high
);

  // Stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result keeps period_count, a_high and c_low stable
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(period_count) && $stable(a_high) && $stable(c_low))
    else $error("result payload changed while stalled");

  // Input is blocked right after a config write, as timing is recomputed
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_ready)
    else $error("input taken right after config write");

  // Every pair is ordered, low side never above high side
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (a_low <= a_high) && (b_low <= b_high) && (c_low <= c_high))
    else $error("compare pair out of order");

endmodule

bind three_phase_pwm_compare_calc tpc_checker u_tpc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .cfg_wr_en    (cfg_wr_en),
  .period_count (out_chan.period_count),
  .a_low        (out_chan.a_low_compare),
  .a_high       (out_chan.a_high_compare),
  .b_low        (out_chan.b_low_compare),
  .b_high       (out_chan.b_high_compare),
  .c_low        (out_chan.c_low_compare),
  .c_high       (out_chan.c_high_compare)
);
